[rtl/timed_event_queue_macros.svh]
// Assertion macros for the timed event queue checker.
// Uses the checker's i_clk and i_rst_n; no other dependencies.
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/teq_pkg.sv]
// Shared types and constants for the timed event queue.
// No dependencies.
`default_nettype none

package teq_pkg;

    localparam int CMD_W   = 3;
    localparam int TIME_W  = 32;
    localparam int OWNER_W = 16;
    localparam int KIND_W  = 4;
    localparam int PAY_W   = 32;

    localparam int DEPTH_DEF = 64;
    // most events popped by one fire request
    localparam int MAX_OUT   = 64;
    localparam int NF_W      = $clog2(MAX_OUT + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHED    = 3'd0,
        CMD_REM_OWN  = 3'd1,
        CMD_REM_OK   = 3'd2,
        CMD_LOOKUP   = 3'd3,
        CMD_FIRE     = 3'd4,
        CMD_FLUSH    = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0]  due;
        logic [OWNER_W-1:0] owner;
        logic [KIND_W-1:0]  kind;
        logic [PAY_W-1:0]   payload;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } t_cell_op;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_op op;
        logic     wr_en;
        t_entry   ent;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/teq_if.sv]
// Request and result channel interfaces for the timed event queue.
// Depends on teq_pkg for field widths.
`default_nettype none

interface teq_in_if;
    logic                        valid;
    logic                        ready;
    logic [teq_pkg::CMD_W-1:0]   cmd;
    logic [teq_pkg::TIME_W-1:0]  now;
    logic [teq_pkg::TIME_W-1:0]  delay;
    logic [teq_pkg::OWNER_W-1:0] owner;
    logic [teq_pkg::KIND_W-1:0]  kind;
    logic [teq_pkg::PAY_W-1:0]   payload;

    modport source (output valid, cmd, now, delay, owner, kind, payload, input ready);
    modport sink   (input valid, cmd, now, delay, owner, kind, payload, output ready);
endinterface

interface teq_out_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic                        event_valid;
    logic [teq_pkg::OWNER_W-1:0] event_owner;
    logic [teq_pkg::KIND_W-1:0]  event_kind;
    logic [teq_pkg::PAY_W-1:0]   event_payload;
    logic                        found;
    logic [teq_pkg::TIME_W-1:0]  head_time;
    logic                        is_empty;
    logic                        last;

    modport source (output valid, status, event_valid, event_owner, event_kind,
                    event_payload, found, head_time, is_empty, last, input ready);
    modport sink   (input valid, status, event_valid, event_owner, event_kind,
                    event_payload, found, head_time, is_empty, last, output ready);
endinterface

`default_nettype wire

[rtl/teq_cell.sv]
// One slot of the sorted event row.
// Depends on teq_pkg; instantiated DEPTH times by timed_event_queue.
`default_nettype none

module teq_cell #(
    parameter int DEPTH = teq_pkg::DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire teq_pkg::t_cell_ctl i_ctl,
    input  wire logic [CW-1:0]      i_count,
    input  wire logic [CW-1:0]      i_wr_idx,
    input  wire teq_pkg::t_entry    i_left,
    input  wire logic               i_left_gt,
    input  wire teq_pkg::t_entry    i_right,
    output      teq_pkg::t_entry    o_ent,
    output      logic               o_gt
);

    teq_pkg::t_entry r_ent;
    teq_pkg::t_entry n_ent;
    logic            w_occ;
    logic            w_mine;

    assign w_occ  = CW'(IDX) < i_count;
    assign w_mine = CW'(IDX) == i_count;
    // strictly later than the new event: new one goes ahead of it
    assign o_gt   = w_occ && (r_ent.due > i_ctl.ent.due);
    assign o_ent  = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.op)
            teq_pkg::CELL_INSERT: begin
                if (i_left_gt) begin
                    n_ent = i_left;
                end else if (o_gt || w_mine) begin
                    n_ent = i_ctl.ent;
                end
            end
            teq_pkg::CELL_ROTATE: begin
                if (i_ctl.wr_en && (i_wr_idx == CW'(IDX))) begin
                    n_ent = i_ctl.ent;
                end else begin
                    n_ent = i_right;
                end
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

[rtl/timed_event_queue.sv]
// Timed event queue: a row of DEPTH cells kept in due-time order, with its controller.
// Depends on teq_pkg, teq_if and teq_cell.
//
// The queue holds up to DEPTH events sorted by due time; equal times keep arrival
// order. One request is taken at a time, only while the controller is idle. A
// schedule into a row with room goes through one insert step, in which every cell
// compares its due time with the new one and shifts right by one if later; flush
// and unused codes go straight to the result. Remove-owner, remove-owner-kind and
// lookup rotate the whole row once through the head cell, one entry per cycle, and
// a kept entry is written back at the tail, so order is preserved. Fire emits one
// result per cycle while events are due and the sink is not stalling (the row
// shifts toward the head once per pop), at most MAX_OUT per request, or a single
// empty result. Results sit in an output register, so a stalled sink only delays
// the next result. The row has no clearing pass; after reset it is empty at once.
`default_nettype none

module timed_event_queue #(
    parameter int DEPTH = teq_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    teq_in_if.sink     i_req,
    teq_out_if.source  o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_WALK,
        S_FIRE,
        S_RESP
    } t_state;

    // ---------------------------------------------------------------- state
    t_state                       r_state;
    logic [teq_pkg::CMD_W-1:0]    r_cmd;
    logic [teq_pkg::TIME_W-1:0]   r_now;
    logic [teq_pkg::OWNER_W-1:0]  r_own;
    logic [teq_pkg::KIND_W-1:0]   r_knd;
    teq_pkg::t_entry              r_new;
    logic [CW-1:0]                r_count;   // events in the row
    logic [CW-1:0]                r_n;       // rows live during a walk
    logic [CW-1:0]                r_left;    // entries still to visit in a walk
    logic                         r_status;
    logic                         r_found;
    logic [teq_pkg::PAY_W-1:0]    r_fpay;
    logic [teq_pkg::NF_W-1:0]     r_nfire;

    // output register
    logic                         r_ovalid;
    logic                         r_ostatus;
    logic                         r_oevalid;
    logic [teq_pkg::OWNER_W-1:0]  r_oowner;
    logic [teq_pkg::KIND_W-1:0]   r_okind;
    logic [teq_pkg::PAY_W-1:0]    r_opay;
    logic                         r_ofound;
    logic [teq_pkg::TIME_W-1:0]   r_ohead;
    logic                         r_oempty;
    logic                         r_olast;

    // ---------------------------------------------------------------- cell row
    teq_pkg::t_cell_ctl           w_ctl;
    logic [CW-1:0]                w_wr_idx;
    teq_pkg::t_entry              w_ent  [0:DEPTH];
    teq_pkg::t_entry              w_lent [0:DEPTH-1];
    logic                         w_gt   [0:DEPTH-1];
    logic                         w_lgt  [0:DEPTH-1];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_lent[g] = '0;
            assign w_lgt[g]  = 1'b0;
        end else begin : g_rest
            assign w_lent[g] = w_ent[g-1];
            assign w_lgt[g]  = w_gt[g-1];
        end

        teq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_wr_idx  (w_wr_idx),
            .i_left    (w_lent[g]),
            .i_left_gt (w_lgt[g]),
            .i_right   (w_ent[g+1]),
            .o_ent     (w_ent[g]),
            .o_gt      (w_gt[g])
        );
    end
    // the tail cell shifts in a copy of itself; it is never read as live data
    assign w_ent[DEPTH] = w_ent[DEPTH-1];

    // ---------------------------------------------------------------- decode
    logic w_out_free;
    logic w_load;
    logic w_accept;
    logic w_match;
    logic w_keep;
    logic w_fire_due;
    logic w_fire_more;

    assign w_out_free = !r_ovalid || o_rsp.ready;
    // a result goes into the output register this cycle
    assign w_load     = ((r_state == S_FIRE) || (r_state == S_RESP)) && w_out_free;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept   = i_req.valid && i_req.ready;

    // head entry against the owner/kind of a remove or lookup
    assign w_match = (w_ent[0].owner == r_own) &&
                     ((r_cmd == teq_pkg::CMD_REM_OWN) || (w_ent[0].kind == r_knd));
    assign w_keep  = (r_cmd == teq_pkg::CMD_LOOKUP) || !w_match;

    assign w_fire_due  = (r_count != '0) && (w_ent[0].due <= r_now) &&
                         (r_nfire < teq_pkg::NF_W'(teq_pkg::MAX_OUT));
    // is another pop possible after this one
    assign w_fire_more = (r_count > CW'(1)) && (w_ent[1].due <= r_now) &&
                         ((r_nfire + teq_pkg::NF_W'(1)) < teq_pkg::NF_W'(teq_pkg::MAX_OUT));

    always_comb begin
        w_ctl.op    = teq_pkg::CELL_HOLD;
        w_ctl.wr_en = 1'b0;
        w_ctl.ent   = r_new;
        w_wr_idx    = r_n - CW'(1);
        case (r_state)
            S_INS: begin
                w_ctl.op = teq_pkg::CELL_INSERT;
            end
            S_WALK: begin
                if (r_left != '0) begin
                    w_ctl.op    = teq_pkg::CELL_ROTATE;
                    w_ctl.wr_en = w_keep;
                    w_ctl.ent   = w_ent[0];
                end
            end
            S_FIRE: begin
                if (w_out_free && w_fire_due) begin
                    w_ctl.op = teq_pkg::CELL_ROTATE;
                end
            end
            default: w_ctl.op = teq_pkg::CELL_HOLD;
        endcase
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd         <= i_req.cmd;
                        r_now         <= i_req.now;
                        r_own         <= i_req.owner;
                        r_knd         <= i_req.kind;
                        r_new.due     <= i_req.now + i_req.delay;
                        r_new.owner   <= i_req.owner;
                        r_new.kind    <= i_req.kind;
                        r_new.payload <= i_req.payload;
                        // full status only for a schedule into a full row
                        r_status      <= (i_req.cmd == teq_pkg::CMD_SCHED) &&
                                         (r_count == CW'(DEPTH));
                        r_found       <= 1'b0;
                        r_fpay        <= '0;
                        r_nfire       <= '0;
                        r_n           <= r_count;
                        r_left        <= r_count;
                        case (i_req.cmd)
                            teq_pkg::CMD_SCHED: begin
                                if (r_count == CW'(DEPTH)) begin
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state  <= S_INS;
                                end
                            end
                            teq_pkg::CMD_REM_OWN,
                            teq_pkg::CMD_REM_OK,
                            teq_pkg::CMD_LOOKUP: r_state <= S_WALK;
                            teq_pkg::CMD_FIRE:   r_state <= S_FIRE;
                            teq_pkg::CMD_FLUSH: begin
                                r_count <= '0;
                                r_state <= S_RESP;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_INS: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_RESP;
                end
                S_WALK: begin
                    if (r_left == '0) begin
                        r_count <= r_n;
                        r_state <= S_RESP;
                    end else begin
                        r_left <= r_left - CW'(1);
                        if (!w_keep) begin
                            r_n <= r_n - CW'(1);
                        end
                        if ((r_cmd == teq_pkg::CMD_LOOKUP) && w_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fpay  <= w_ent[0].payload;
                        end
                    end
                end
                S_FIRE: begin
                    if (w_out_free) begin
                        r_ostatus <= 1'b0;
                        r_ofound  <= 1'b0;
                        if (w_fire_due) begin
                            // pop the head; the row shifts toward it this cycle
                            r_count   <= r_count - CW'(1);
                            r_nfire   <= r_nfire + teq_pkg::NF_W'(1);
                            r_oevalid <= 1'b1;
                            r_oowner  <= w_ent[0].owner;
                            r_okind   <= w_ent[0].kind;
                            r_opay    <= w_ent[0].payload;
                            r_ohead   <= (r_count > CW'(1)) ? w_ent[1].due : '0;
                            r_oempty  <= (r_count == CW'(1));
                            r_olast   <= !w_fire_more;
                            if (!w_fire_more) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            // nothing due
                            r_oevalid <= 1'b0;
                            r_oowner  <= '0;
                            r_okind   <= '0;
                            r_opay    <= '0;
                            r_ohead   <= (r_count != '0) ? w_ent[0].due : '0;
                            r_oempty  <= (r_count == '0);
                            r_olast   <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_ostatus <= r_status;
                        r_oevalid <= 1'b0;
                        r_oowner  <= '0;
                        r_okind   <= '0;
                        r_opay    <= r_fpay;
                        r_ofound  <= r_found;
                        r_ohead   <= (r_count != '0) ? w_ent[0].due : '0;
                        r_oempty  <= (r_count == '0);
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.event_valid   = r_oevalid;
    assign o_rsp.event_owner   = r_oowner;
    assign o_rsp.event_kind    = r_okind;
    assign o_rsp.event_payload = r_opay;
    assign o_rsp.found         = r_ofound;
    assign o_rsp.head_time     = r_ohead;
    assign o_rsp.is_empty      = r_oempty;
    assign o_rsp.last          = r_olast;

endmodule

`default_nettype wire

[rtl/teq_checker.sv]
// Port-level checks for timed_event_queue, attached by bind.
// Depends on teq_pkg and timed_event_queue_macros.svh.
`default_nettype none

`include "timed_event_queue_macros.svh"

module teq_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        i_status,
    input wire logic                        i_event_valid,
    input wire logic                        i_found,
    input wire logic [teq_pkg::TIME_W-1:0]  i_head_time,
    input wire logic                        i_is_empty,
    input wire logic                        i_last
);

    // a stalled result stays offered
    `TEQ_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // empty queue reports a zero head time
    `TEQ_ASSERT_IMP(a_empty_head, i_out_valid && i_is_empty, i_head_time == '0, "empty with nonzero head time")

    // a full status is a single plain result
    `TEQ_ASSERT_IMP(a_full_plain, i_out_valid && i_status, i_last && !i_event_valid && !i_found, "full status on non-plain result")

    // fired event and lookup hit never share a result
    `TEQ_ASSERT_IMP(a_fire_vs_found, i_out_valid && i_event_valid, !i_found && !i_status, "fired event flagged as lookup or full")

endmodule

bind timed_event_queue teq_checker u_teq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_event_valid (o_rsp.event_valid),
    .i_found       (o_rsp.found),
    .i_head_time   (o_rsp.head_time),
    .i_is_empty    (o_rsp.is_empty),
    .i_last        (o_rsp.last)
);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the timed event queue: directed and random requests,
// checked against a behavioral model of the sorted queue kept in this file.
// Depends on teq_pkg, teq_if and the timed_event_queue RTL.
`timescale 1ns / 1ps

module tb_top;
    import teq_pkg::*;

    localparam int QDEPTH       = DEPTH_DEF;
    localparam int RAND_REQS    = 358;
    // no-progress limit: covers the long hold-off, the longest gaps and a full-row walk
    localparam int WDOG_LIMIT   = 2000;
    // run-out after the drain, long enough for a remove or lookup over a full row
    localparam int TAIL_CYCLES  = QDEPTH + 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;

    // command codes the block does not define; it must answer them with a plain result
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  delay;
        logic [OWNER_W-1:0] owner;
        logic [KIND_W-1:0]  kind;
        logic [PAY_W-1:0]   payload;
    } t_req;

    typedef struct {
        logic               status;
        logic               ev_valid;
        logic [OWNER_W-1:0] ev_owner;
        logic [KIND_W-1:0]  ev_kind;
        logic [PAY_W-1:0]   ev_payload;
        logic               found;
        logic [TIME_W-1:0]  head_time;
        logic               is_empty;
        logic               last;
    } t_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    teq_in_if  req_if ();
    teq_out_if rsp_if ();

    timed_event_queue #(.DEPTH(QDEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Single reset at start; synchronous, released on a rising edge.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Known values on every block input from time zero.
    initial begin
        req_if.valid   = 1'b0;
        req_if.cmd     = CMD_FLUSH;
        req_if.now     = '0;
        req_if.delay   = '0;
        req_if.owner   = '0;
        req_if.kind    = '0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
    end

    t_req   req_backlog[$];   // requests not yet offered
    t_entry queue_model[$];   // pending events, index 0 is the head
    t_rsp   awaited_rsps[$];  // results owed by the block, oldest first
    int     n_fail = 0;
    int     n_items = 0;
    int     n_rsp = 0;

    // ------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------

    // Queue one expected result; head/empty are taken from the model as it is now,
    // so callers push after they have changed the queue.
    function automatic void await_rsp(logic status, logic ev_valid, logic [OWNER_W-1:0] owner,
                                      logic [KIND_W-1:0] kind, logic [PAY_W-1:0] payload,
                                      logic found, logic last);
        t_rsp r;
        r.status     = status;
        r.ev_valid   = ev_valid;
        r.ev_owner   = owner;
        r.ev_kind    = kind;
        r.ev_payload = payload;
        r.found      = found;
        r.head_time  = (queue_model.size() != 0) ? queue_model[0].due : '0;
        r.is_empty   = (queue_model.size() == 0);
        r.last       = last;
        awaited_rsps.push_back(r);
    endfunction

    // Apply one accepted request to the model and record the results it owes.
    function automatic void apply_request(t_req r);
        logic [TIME_W-1:0] due;
        t_entry            ent;
        int                pos;
        int                n_pop;
        bit                hit;
        case (r.cmd)
            CMD_SCHED: begin
                due = r.now + r.delay;   // wraps mod 2^32 on purpose
                if (queue_model.size() >= QDEPTH) begin
                    await_rsp(1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    // after every event due at or before it: equal times stay in arrival order
                    pos = 0;
                    while (pos < queue_model.size() && queue_model[pos].due <= due)
                        pos++;
                    ent.due     = due;
                    ent.owner   = r.owner;
                    ent.kind    = r.kind;
                    ent.payload = r.payload;
                    queue_model.insert(pos, ent);
                    await_rsp(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
                end
            end
            CMD_REM_OWN, CMD_REM_OK: begin
                pos = 0;
                while (pos < queue_model.size()) begin
                    if (queue_model[pos].owner == r.owner &&
                        (r.cmd == CMD_REM_OWN || queue_model[pos].kind == r.kind))
                        queue_model.delete(pos);
                    else
                        pos++;
                end
                await_rsp(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
            CMD_LOOKUP: begin
                hit = 1'b0;
                foreach (queue_model[k]) begin
                    if (!hit && queue_model[k].owner == r.owner && queue_model[k].kind == r.kind) begin
                        hit = 1'b1;
                        await_rsp(1'b0, 1'b0, '0, '0, queue_model[k].payload, 1'b1, 1'b1);
                    end
                end
                if (!hit)
                    await_rsp(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
            CMD_FIRE: begin
                // head time on each result is the one left after that pop
                n_pop = 0;
                while (n_pop < MAX_OUT && queue_model.size() != 0 && queue_model[0].due <= r.now) begin
                    ent = queue_model.pop_front();
                    await_rsp(1'b0, 1'b1, ent.owner, ent.kind, ent.payload, 1'b0, 1'b0);
                    n_pop++;
                end
                if (n_pop == 0)
                    await_rsp(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
                else
                    awaited_rsps[awaited_rsps.size()-1].last = 1'b1;
            end
            CMD_FLUSH: begin
                queue_model.delete();
                await_rsp(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
            default: begin
                await_rsp(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_req(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
                                    logic [TIME_W-1:0] delay, logic [OWNER_W-1:0] owner,
                                    logic [KIND_W-1:0] kind, logic [PAY_W-1:0] payload);
        t_req r;
        r.cmd     = cmd;
        r.now     = now;
        r.delay   = delay;
        r.owner   = owner;
        r.kind    = kind;
        r.payload = payload;
        req_backlog.push_back(r);
        n_items++;
    endfunction

    // Small owner/kind pools so removes and lookups actually hit something.
    function automatic logic [OWNER_W-1:0] rand_owner();
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r == 4) return '1;
        if (r == 5) return OWNER_W'($urandom);
        return OWNER_W'(r);
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        return KIND_W'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2));
    endfunction

    function automatic logic [TIME_W-1:0] rand_delay();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 40);
        if (r < 9) return $urandom_range(0, 1000);
        return $urandom;
    endfunction

    // One weighted random request around the running time base.
    function automatic void add_random_op(logic [TIME_W-1:0] t_now);
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < 40)
            add_req(CMD_SCHED, t_now, rand_delay(), rand_owner(), rand_kind(), $urandom);
        else if (w < 60)
            add_req(CMD_FIRE, t_now, $urandom, OWNER_W'($urandom), KIND_W'($urandom), $urandom);
        else if (w < 72)
            add_req(CMD_LOOKUP, $urandom, $urandom, rand_owner(), rand_kind(), $urandom);
        else if (w < 80)
            add_req(CMD_REM_OWN, $urandom, $urandom, rand_owner(), KIND_W'($urandom), $urandom);
        else if (w < 90)
            add_req(CMD_REM_OK, $urandom, $urandom, rand_owner(), rand_kind(), $urandom);
        else if (w < 93)
            add_req(CMD_FLUSH, $urandom, $urandom, OWNER_W'($urandom), KIND_W'($urandom),
                    $urandom);
        else if (w < 96)
            add_req(($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7,
                    $urandom, $urandom, OWNER_W'($urandom), KIND_W'($urandom), $urandom);
        else
            add_req(CMD_W'($urandom_range(0, 7)), $urandom, $urandom, OWNER_W'($urandom),
                    KIND_W'($urandom), $urandom);
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    t_req        cur_req;
    int unsigned tx_gap = 0;
    bit          tx_steady = 1'b0;   // stretch with no gaps

    always @(posedge i_clk) begin
        logic vld_nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            vld_nxt = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                apply_request(cur_req);
                vld_nxt = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                tx_gap = tx_steady ? 0 : pick_gap();
            end
            if (!vld_nxt) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (req_backlog.size() != 0) begin
                    cur_req = req_backlog.pop_front();
                    req_if.cmd     <= cur_req.cmd;
                    req_if.now     <= cur_req.now;
                    req_if.delay   <= cur_req.delay;
                    req_if.owner   <= cur_req.owner;
                    req_if.kind    <= cur_req.kind;
                    req_if.payload <= cur_req.payload;
                    vld_nxt = 1'b1;
                end
            end
            // one assignment per edge: a valid that stays high is never dropped in between
            req_if.valid <= vld_nxt;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------
    int unsigned rx_hold = 0;
    bit          rx_steady = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_r;
        logic rdy_nxt;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_rsp++;
                if (awaited_rsps.size() == 0) begin
                    $error("result with no request outstanding");
                    n_fail++;
                end else begin
                    exp_r = awaited_rsps.pop_front();
                    check_field("status",        32'(exp_r.status),     32'(rsp_if.status));
                    check_field("event_valid",   32'(exp_r.ev_valid),   32'(rsp_if.event_valid));
                    check_field("event_owner",   32'(exp_r.ev_owner),   32'(rsp_if.event_owner));
                    check_field("event_kind",    32'(exp_r.ev_kind),    32'(rsp_if.event_kind));
                    check_field("event_payload", exp_r.ev_payload,      rsp_if.event_payload);
                    check_field("found",         32'(exp_r.found),      32'(rsp_if.found));
                    check_field("head_time",     exp_r.head_time,       rsp_if.head_time);
                    check_field("is_empty",      32'(exp_r.is_empty),   32'(rsp_if.is_empty));
                    check_field("last",          32'(exp_r.last),       32'(rsp_if.last));
                end
                if ($urandom_range(0, 49) == 0)
                    rx_steady = !rx_steady;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rdy_nxt = 1'b0;
            end else if (!long_hold_done && n_rsp >= HOLD_AFTER) begin
                // back-pressure: sink goes away long enough for the request side to stall
                long_hold_done = 1'b1;
                rx_hold = HOLD_CYCLES - 1;
                rdy_nxt = 1'b0;
            end else begin
                rx_hold = (rx_steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
                rdy_nxt = (rx_hold == 0);
                if (rx_hold > 0)
                    rx_hold--;
            end
            rsp_if.ready <= rdy_nxt;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake on either side for too long ends the run
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $error("no progress for %0d cycles, %0d results still owed",
                       WDOG_LIMIT, awaited_rsps.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0] t_now;
        int                n_fill;
        int                burst;
        int                goal;

        // Directed part: empty-queue behavior, wrapped and extreme due times,
        // ties in due time, lookup hit/miss, removes, spare codes, fire, flush.
        add_req(CMD_FIRE,    32'd0,          32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_LOOKUP,  32'd0,          32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_REM_OWN, 32'd0,          32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_SCHED,   32'hFFFF_FFFF,  32'd1,          16'd0,    4'd0,  32'd0);
        add_req(CMD_SCHED,   32'd0,          32'hFFFF_FFFF,  16'hFFFF, 4'hF,  32'hFFFF_FFFF);
        add_req(CMD_SCHED,   32'd90,         32'd10,         16'd5,    4'd3,  32'h1111_0001);
        add_req(CMD_SCHED,   32'd100,        32'd0,          16'd5,    4'd4,  32'h1111_0002);
        add_req(CMD_SCHED,   32'd50,         32'd50,         16'd5,    4'd3,  32'h1111_0003);
        add_req(CMD_SCHED,   32'd100,        32'd0,          16'd6,    4'd3,  32'h1111_0004);
        add_req(CMD_LOOKUP,  32'd0,          32'd0,          16'd5,    4'd3,  32'd0);
        add_req(CMD_LOOKUP,  32'd0,          32'd0,          16'd5,    4'd9,  32'd0);
        add_req(CMD_LOOKUP,  32'd0,          32'd0,          16'hFFFF, 4'hF,  32'd0);
        add_req(CMD_REM_OK,  32'd0,          32'd0,          16'd5,    4'd3,  32'd0);
        add_req(CMD_SPARE6,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  16'hFFFF, 4'hF,  32'hFFFF_FFFF);
        add_req(CMD_SPARE7,  32'd0,          32'd0,          16'd5,    4'd4,  32'd0);
        add_req(CMD_FIRE,    32'd99,         32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_FIRE,    32'd100,        32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_FIRE,    32'd100,        32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_REM_OWN, 32'd0,          32'd0,          16'hFFFF, 4'd0,  32'd0);
        add_req(CMD_SCHED,   32'd7,          32'd3,          16'd2,    4'd1,  32'h5A5A_A5A5);
        add_req(CMD_FLUSH,   32'd0,          32'd0,          16'd0,    4'd0,  32'd0);
        add_req(CMD_FIRE,    32'hFFFF_FFFF,  32'd0,          16'd0,    4'd0,  32'd0);

        // Random part in bursts: ordinary mixes, mixes near the top of the time
        // range so due times wrap, and a couple of fill-to-full passes.
        goal   = n_items + RAND_REQS;
        t_now  = $urandom_range(0, 1000);
        n_fill = 0;
        while (n_items < goal) begin
            case ($urandom_range(0, 9))
                0: begin
                    if (n_fill < 2) begin
                        n_fill++;
                        add_req(CMD_FLUSH, $urandom, $urandom, OWNER_W'($urandom),
                                KIND_W'($urandom), $urandom);
                        // two past capacity to see the full status
                        for (int k = 0; k < QDEPTH + 2; k++)
                            add_req(CMD_SCHED, t_now, $urandom_range(0, 50), rand_owner(),
                                    rand_kind(), $urandom);
                        if ($urandom_range(0, 1) != 0)
                            add_req(CMD_REM_OWN, $urandom, $urandom, rand_owner(),
                                    KIND_W'($urandom), $urandom);
                        // everything is due: one fire drains the whole row
                        add_req(CMD_FIRE, 32'hFFFF_FFFF, $urandom, OWNER_W'($urandom),
                                KIND_W'($urandom), $urandom);
                    end
                end
                1: begin
                    t_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    burst = $urandom_range(8, 24);
                    for (int k = 0; k < burst; k++) begin
                        add_random_op(t_now);
                        t_now += $urandom_range(0, 20);
                    end
                end
                default: begin
                    burst = $urandom_range(8, 30);
                    for (int k = 0; k < burst; k++) begin
                        add_random_op(t_now);
                        t_now += $urandom_range(0, 20);
                    end
                end
            endcase
        end

        // Drain: sampled on the falling edge so the driver's updates are settled.
        do @(negedge i_clk);
        while (!i_rst_n || req_backlog.size() != 0 || req_if.valid || awaited_rsps.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
